@@ sv/regime_gated_band_reversion_macros.svh @@
// Assertion macros shared by the band reversion RTL.
`ifndef REGIME_GATED_BAND_REVERSION_MACROS_SVH
`define REGIME_GATED_BAND_REVERSION_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the block clock, off during reset.
`define RGBR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on the block clock, off during reset.
`define RGBR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RGBR_ASSERT_IMP(label, ante, cons, msg)
`define RGBR_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ sv/rgbr_pkg.sv @@
// Shared constants, types and helpers of the band reversion block.
package rgbr_pkg;

   localparam int BAND_WINDOW    = 20;
   localparam int RATIO_LOOKBACK = 10;
   localparam int PRICE_BITS     = 32;

   localparam int CLOSE_BITS = 32;
   localparam int PCT_BITS   = 7;
   localparam int MULT_BITS  = 7;
   localparam int PCT_SCALE  = 100;

   localparam int LAG_BITS  = $clog2(BAND_WINDOW + 1);
   localparam int SLOT_BITS = $clog2(BAND_WINDOW);
   localparam int SUM_BITS  = PRICE_BITS + $clog2(BAND_WINDOW);
   localparam int SQ_BITS   = 2 * PRICE_BITS;
   localparam int Q_BITS    = SQ_BITS + $clog2(BAND_WINDOW);
   localparam int T_BITS    = Q_BITS + $clog2(BAND_WINDOW);
   localparam int TOT_BITS  = PRICE_BITS + $clog2(RATIO_LOOKBACK);
   localparam int GATE_BITS = TOT_BITS + PCT_BITS;
   localparam int M2_BITS   = 2 * MULT_BITS;
   localparam int M2W_BITS  = M2_BITS + $clog2(BAND_WINDOW + 1);

   // Deviation side of the band test: (W*c - S)^2 * 100 * (W - 1).
   localparam int LHS_SCALE  = PCT_SCALE * (BAND_WINDOW - 1);
   localparam int SCALE_BITS = $clog2(LHS_SCALE + 1);

   localparam int DIGIT_BITS = 8;
   localparam int B_RAW_0    = (SUM_BITS > M2W_BITS) ? SUM_BITS : M2W_BITS;
   localparam int B_RAW      = (B_RAW_0 > SCALE_BITS) ? B_RAW_0 : SCALE_BITS;
   localparam int MUL_B_BITS = ((B_RAW + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
   localparam int MUL_A_BITS = (T_BITS > 2 * SUM_BITS) ? T_BITS : 2 * SUM_BITS;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 7;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GATE_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RATIO_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BAND_MULT       = 2'd2;

   localparam logic                 GATE_RESET   = 1'b1;
   localparam logic [PCT_BITS-1:0]  THRESH_RESET = 7'd35;
   localparam logic [MULT_BITS-1:0] MULT_RESET   = 7'd20;

   localparam logic signed [1:0] DIR_LONG  = 2'sb01;
   localparam logic signed [1:0] DIR_SHORT = 2'sb11;
   localparam logic signed [1:0] DIR_NONE  = 2'sb00;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_GATE,
      ST_DECIDE,
      ST_SQ_SUM,
      ST_SPREAD,
      ST_SQ_DEV,
      ST_LHS,
      ST_RHS,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                clear;
      logic                rd_en;
      logic [LAG_BITS-1:0] rd_lag;
      logic                wr_en;
   } ring_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   function automatic logic [PRICE_BITS-1:0] abs_diff(input logic [PRICE_BITS-1:0] a,
                                                      input logic [PRICE_BITS-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

@@ sv/rgbr_chan_if.sv @@
// Request and response channel interfaces of the band reversion block.
interface rgbr_req_if;
   logic                             valid;
   logic                             ready;
   logic [rgbr_pkg::CLOSE_BITS-1:0]  close_price;
   logic                             clear_history;

   modport source (output valid, close_price, clear_history, input ready);
   modport sink   (input valid, close_price, clear_history, output ready);
endinterface

interface rgbr_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [1:0] direction;
   logic              history_ready;

   modport source (output valid, direction, history_ready, input ready);
   modport sink   (input valid, direction, history_ready, output ready);
endinterface

@@ sv/regime_gated_band_reversion.sv @@
// Top level: band reversion signal with efficiency ratio gate per closing bar.
//
//   channel   dir   handshake        payload
//   req_bus   in    valid / ready    close_price[31:0], clear_history
//   rsp_bus   out   valid / ready    direction[1:0] signed, history_ready
//   csr_*     in    csr_wr_en        csr_index[1:0], csr_wr_data[6:0]
//
// Without a full window a bar goes straight to the output state. A full window
// adds 20 history reads (one entry a cycle) and a drain, then the gate test and,
// unless the gate suppresses the bar, up to four byte-serial products.
// Reset is synchronous; the ring contents are not cleared, only its count and slot.
// A new bar is accepted while a finished result waits in the output
// register; its ring write waits until that register is free.
`include "regime_gated_band_reversion_macros.svh"

module regime_gated_band_reversion (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [rgbr_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [rgbr_pkg::CSR_DATA_BITS-1:0]    csr_wr_data,
   rgbr_req_if.sink                              req_bus,
   rgbr_rsp_if.source                            rsp_bus
);
   localparam int PBITS   = rgbr_pkg::PRICE_BITS;
   localparam int LBITS   = rgbr_pkg::LAG_BITS;
   localparam int SUMBITS = rgbr_pkg::SUM_BITS;
   localparam int SQBITS  = rgbr_pkg::SQ_BITS;
   localparam int QBITS   = rgbr_pkg::Q_BITS;
   localparam int TBITS   = rgbr_pkg::T_BITS;
   localparam int TOTBITS = rgbr_pkg::TOT_BITS;
   localparam int GBITS   = rgbr_pkg::GATE_BITS;
   localparam int M2BITS  = rgbr_pkg::M2_BITS;
   localparam int M2WBITS = rgbr_pkg::M2W_BITS;
   localparam int ABITS   = rgbr_pkg::MUL_A_BITS;
   localparam int BBITS   = rgbr_pkg::MUL_B_BITS;
   localparam int MPBITS  = rgbr_pkg::MUL_P_BITS;
   localparam int WIN     = rgbr_pkg::BAND_WINDOW;
   localparam int LOOK    = rgbr_pkg::RATIO_LOOKBACK;

   // Configuration.
   logic                               gate_en_ff, gate_en_in;
   logic [rgbr_pkg::PCT_BITS-1:0]      thr_ff, thr_in;
   logic [rgbr_pkg::MULT_BITS-1:0]     mult_ff, mult_in;

   // Control.
   rgbr_pkg::state_type                state_ff, state_in;
   logic                               req_ready;
   logic                               walk_init;
   rgbr_pkg::ring_cmd_type             ring_cmd;
   logic [PBITS-1:0]                   ring_rd_data;
   logic                               ring_full;
   logic                               mul_start;
   logic [ABITS-1:0]                   mul_a;
   logic [BBITS-1:0]                   mul_b;
   logic [MPBITS-1:0]                  mul_prod;
   rgbr_pkg::mul_stat_type             mul_stat;
   logic [LBITS-1:0]                   lag_ff, lag_in;
   logic [LBITS-1:0]                   tag_ff, tag_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic                               sq_vld_ff, sq_vld_in;

   // Bar in work.
   logic [PBITS-1:0]                   close_c;
   logic [PBITS-1:0]                   price_ff, price_in;
   logic                               hist_ff, hist_in;
   logic signed [1:0]                  dir_res_ff, dir_res_in;

   // Window walk accumulators.
   logic [SQBITS-1:0]                  sq_ff, sq_in;
   logic [SUMBITS-1:0]                 sum_ff, sum_in;
   logic [QBITS-1:0]                   q_ff, q_in;
   logic [PBITS-1:0]                   prev_ff, prev_in;
   logic [TOTBITS-1:0]                 tot_ff, tot_in;
   logic [PBITS-1:0]                   net_ff, net_in;

   // Derived terms.
   logic [GBITS-1:0]                   net100_ff, net100_in;
   logic [GBITS-1:0]                   thrtot_ff, thrtot_in;
   logic [M2BITS-1:0]                  m2_ff, m2_in;
   logic [M2WBITS-1:0]                 m2w_ff, m2w_in;
   logic [TBITS-1:0]                   q20_ff, q20_in;
   logic [SUMBITS-1:0]                 wc_ff, wc_in;
   logic [TBITS-1:0]                   t_ff, t_in;
   logic                               below_ff, below_in;
   logic [MPBITS-1:0]                  lhs_ff, lhs_in;
   logic [TBITS-1:0]                   spread;
   logic [SUMBITS-1:0]                 dev;

   // Output register.
   logic                               rsp_vld_ff, rsp_vld_in;
   logic signed [1:0]                  rsp_dir_ff, rsp_dir_in;
   logic                               rsp_hist_ff, rsp_hist_in;

   rgbr_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd),
      .wr_data (price_ff),
      .rd_data (ring_rd_data),
      .full    (ring_full)
   );

   rgbr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_prod),
      .stat    (mul_stat)
   );

   assign close_c = PBITS'(req_bus.close_price);

   // Configuration registers.
   always_comb begin
      gate_en_in = gate_en_ff;
      thr_in     = thr_ff;
      mult_in    = mult_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rgbr_pkg::CSR_GATE_ENABLE:     gate_en_in = csr_wr_data[0];
            rgbr_pkg::CSR_RATIO_THRESHOLD: thr_in     = csr_wr_data;
            rgbr_pkg::CSR_BAND_MULT:       mult_in    = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // 20*Q - S^2 equals W*(W-1) times the sample variance.
   assign spread = q20_ff - mul_prod[TBITS-1:0];
   assign dev    = (wc_ff < sum_ff) ? (sum_ff - wc_ff) : (wc_ff - sum_ff);

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      walk_init       = 1'b0;
      ring_cmd        = '0;
      ring_cmd.rd_lag = lag_ff;
      mul_start       = 1'b0;
      mul_a           = '0;
      mul_b           = '0;
      lag_in          = lag_ff;
      price_in        = price_ff;
      hist_in         = hist_ff;
      dir_res_in      = dir_res_ff;
      t_in            = t_ff;
      below_in        = below_ff;
      lhs_in          = lhs_ff;
      rsp_vld_in      = rsp_vld_ff && !rsp_bus.ready;
      rsp_dir_in      = rsp_dir_ff;
      rsp_hist_in     = rsp_hist_ff;
      case (state_ff)
         rgbr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               price_in       = close_c;
               hist_in        = ring_full && !req_bus.clear_history;
               ring_cmd.clear = req_bus.clear_history;
               dir_res_in     = rgbr_pkg::DIR_NONE;
               lag_in         = LBITS'(1);
               walk_init      = 1'b1;
               state_in       = hist_in ? rgbr_pkg::ST_WALK : rgbr_pkg::ST_OUT;
            end
         end
         rgbr_pkg::ST_WALK: begin
            ring_cmd.rd_en = 1'b1;
            lag_in         = lag_ff + 1'b1;
            if (lag_ff == LBITS'(WIN)) begin
               state_in = rgbr_pkg::ST_DRAIN;
            end
         end
         rgbr_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !sq_vld_ff) begin
               state_in = rgbr_pkg::ST_GATE;
            end
         end
         rgbr_pkg::ST_GATE: begin
            state_in = rgbr_pkg::ST_DECIDE;
         end
         rgbr_pkg::ST_DECIDE: begin
            if (gate_en_ff && (net100_ff >= thrtot_ff)) begin
               state_in = rgbr_pkg::ST_OUT;
            end else begin
               mul_start = 1'b1;
               mul_a     = ABITS'(sum_ff);
               mul_b     = BBITS'(sum_ff);
               state_in  = rgbr_pkg::ST_SQ_SUM;
            end
         end
         rgbr_pkg::ST_SQ_SUM: begin
            if (mul_stat.done) begin
               state_in = rgbr_pkg::ST_SPREAD;
            end
         end
         rgbr_pkg::ST_SPREAD: begin
            t_in     = spread;
            below_in = wc_ff < sum_ff;
            if ((spread == '0) || (wc_ff == sum_ff)) begin
               state_in = rgbr_pkg::ST_OUT;
            end else begin
               mul_start = 1'b1;
               mul_a     = ABITS'(dev);
               mul_b     = BBITS'(dev);
               state_in  = rgbr_pkg::ST_SQ_DEV;
            end
         end
         rgbr_pkg::ST_SQ_DEV: begin
            if (mul_stat.done) begin
               mul_start = 1'b1;
               mul_a     = mul_prod[ABITS-1:0];
               mul_b     = BBITS'(rgbr_pkg::LHS_SCALE);
               state_in  = rgbr_pkg::ST_LHS;
            end
         end
         rgbr_pkg::ST_LHS: begin
            if (mul_stat.done) begin
               lhs_in    = mul_prod;
               mul_start = 1'b1;
               mul_a     = ABITS'(t_ff);
               mul_b     = BBITS'(m2w_ff);
               state_in  = rgbr_pkg::ST_RHS;
            end
         end
         rgbr_pkg::ST_RHS: begin
            if (mul_stat.done) begin
               if (lhs_ff > mul_prod) begin
                  dir_res_in = below_ff ? rgbr_pkg::DIR_LONG : rgbr_pkg::DIR_SHORT;
               end else begin
                  dir_res_in = rgbr_pkg::DIR_NONE;
               end
               state_in = rgbr_pkg::ST_OUT;
            end
         end
         rgbr_pkg::ST_OUT: begin
            if (!rsp_vld_ff || rsp_bus.ready) begin
               rsp_vld_in     = 1'b1;
               rsp_dir_in     = dir_res_ff;
               rsp_hist_in    = hist_ff;
               ring_cmd.wr_en = 1'b1;
               state_in       = rgbr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rgbr_pkg::ST_IDLE;
         end
      endcase
   end

   // Window walk: read data arrives the cycle after the read; its square is registered once more.
   always_comb begin
      rd_vld_in = ring_cmd.rd_en;
      tag_in    = lag_ff;
      sq_vld_in = rd_vld_ff;
      sq_in     = sq_ff;
      sum_in    = sum_ff;
      q_in      = q_ff;
      prev_in   = prev_ff;
      tot_in    = tot_ff;
      net_in    = net_ff;
      if (walk_init) begin
         sum_in  = '0;
         q_in    = '0;
         tot_in  = '0;
         net_in  = '0;
         prev_in = close_c;
      end
      if (rd_vld_ff) begin
         sum_in = sum_ff + SUMBITS'(ring_rd_data);
         sq_in  = SQBITS'(ring_rd_data) * SQBITS'(ring_rd_data);
         // The path length runs from the current close back through the
         // lookback span, one step per prior bar.
         if (tag_ff <= LBITS'(LOOK)) begin
            tot_in  = tot_ff + TOTBITS'(rgbr_pkg::abs_diff(prev_ff, ring_rd_data));
            prev_in = ring_rd_data;
         end
         if (tag_ff == LBITS'(LOOK)) begin
            net_in = rgbr_pkg::abs_diff(price_ff, ring_rd_data);
         end
      end
      if (sq_vld_ff) begin
         q_in = q_ff + QBITS'(sq_ff);
      end
   end

   // These settle during the gate state, once the walk has drained.
   always_comb begin
      net100_in = GBITS'(net_ff) * GBITS'(rgbr_pkg::PCT_SCALE);
      thrtot_in = GBITS'(tot_ff) * GBITS'(thr_ff);
      m2_in     = M2BITS'(mult_ff) * M2BITS'(mult_ff);
      m2w_in    = M2WBITS'(m2_ff) * M2WBITS'(WIN);
      q20_in    = TBITS'(q_ff) * TBITS'(WIN);
      wc_in     = SUMBITS'(price_ff) * SUMBITS'(WIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_en_ff <= rgbr_pkg::GATE_RESET;
         thr_ff     <= rgbr_pkg::THRESH_RESET;
         mult_ff    <= rgbr_pkg::MULT_RESET;
         state_ff   <= rgbr_pkg::ST_IDLE;
         rd_vld_ff  <= 1'b0;
         sq_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         gate_en_ff <= gate_en_in;
         thr_ff     <= thr_in;
         mult_ff    <= mult_in;
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         sq_vld_ff  <= sq_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lag_ff      <= lag_in;
      tag_ff      <= tag_in;
      price_ff    <= price_in;
      hist_ff     <= hist_in;
      dir_res_ff  <= dir_res_in;
      sq_ff       <= sq_in;
      sum_ff      <= sum_in;
      q_ff        <= q_in;
      prev_ff     <= prev_in;
      tot_ff      <= tot_in;
      net_ff      <= net_in;
      net100_ff   <= net100_in;
      thrtot_ff   <= thrtot_in;
      m2_ff       <= m2_in;
      m2w_ff      <= m2w_in;
      q20_ff      <= q20_in;
      wc_ff       <= wc_in;
      t_ff        <= t_in;
      below_ff    <= below_in;
      lhs_ff      <= lhs_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_hist_ff <= rsp_hist_in;
   end

   assign req_bus.ready         = req_ready;
   assign rsp_bus.valid         = rsp_vld_ff;
   assign rsp_bus.direction     = rsp_dir_ff;
   assign rsp_bus.history_ready = rsp_hist_ff;

   `RGBR_ASSERT_IMP(a_mul_start_idle, mul_start, !mul_stat.busy, "multiplier restarted while busy")
   `RGBR_ASSERT_NXT(a_ring_write_fills, ring_cmd.wr_en, rsp_vld_ff, "ring written without a result beat")
   `RGBR_ASSERT_NXT(a_cold_bar_skips, req_bus.valid && req_ready && !(ring_full && !req_bus.clear_history), state_ff == rgbr_pkg::ST_OUT, "bar without full history entered the walk")
   `RGBR_ASSERT_IMP(a_cold_bar_quiet, rsp_vld_ff && !rsp_hist_ff, rsp_dir_ff == rgbr_pkg::DIR_NONE, "signal given without full history")

endmodule

@@ sv/rgbr_ring.sv @@
// Close history ring: synchronous memory with write slot and fill count.
module rgbr_ring (
   input  logic                                clock,
   input  logic                                reset,
   input  rgbr_pkg::ring_cmd_type              cmd,
   input  logic [rgbr_pkg::PRICE_BITS-1:0]     wr_data,
   output logic [rgbr_pkg::PRICE_BITS-1:0]     rd_data,
   output logic                                full
);
   localparam int PBITS = rgbr_pkg::PRICE_BITS;
   localparam int SBITS = rgbr_pkg::SLOT_BITS;
   localparam int LBITS = rgbr_pkg::LAG_BITS;
   localparam int AW    = LBITS + 1;
   localparam int DEPTH = rgbr_pkg::BAND_WINDOW;

   logic [PBITS-1:0] mem [DEPTH];
   logic [PBITS-1:0] rd_data_ff;
   logic [SBITS-1:0] slot_ff, slot_in;
   logic [LBITS-1:0] held_ff, held_in;
   logic [AW-1:0]    wrap_sum;
   logic [SBITS-1:0] rd_addr;

   // The entry lag bars back sits behind the write slot, modulo the depth.
   always_comb begin
      wrap_sum = AW'(slot_ff) + AW'(DEPTH) - AW'(cmd.rd_lag);
      if (wrap_sum >= AW'(DEPTH)) begin
         rd_addr = SBITS'(wrap_sum - AW'(DEPTH));
      end else begin
         rd_addr = SBITS'(wrap_sum);
      end
   end

   always_comb begin
      slot_in = slot_ff;
      held_in = held_ff;
      if (cmd.clear) begin
         slot_in = '0;
         held_in = '0;
      end else if (cmd.wr_en) begin
         slot_in = (slot_ff == SBITS'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         if (held_ff != LBITS'(DEPTH)) begin
            held_in = held_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         held_ff <= '0;
      end else begin
         slot_ff <= slot_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[slot_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign full    = (held_ff == LBITS'(DEPTH));

endmodule

@@ sv/rgbr_mul.sv @@
// Digit-serial wide multiplier: one byte of the multiplier per cycle.
module rgbr_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rgbr_pkg::MUL_A_BITS-1:0]     a,
   input  logic [rgbr_pkg::MUL_B_BITS-1:0]     b,
   output logic [rgbr_pkg::MUL_P_BITS-1:0]     product,
   output rgbr_pkg::mul_stat_type              stat
);
   localparam int PBITS = rgbr_pkg::MUL_P_BITS;
   localparam int BBITS = rgbr_pkg::MUL_B_BITS;
   localparam int DBITS = rgbr_pkg::DIGIT_BITS;

   logic [PBITS-1:0] a_ff, a_in;
   logic [BBITS-1:0] b_ff, b_in;
   logic [PBITS-1:0] acc_ff, acc_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // The multiplicand shifts up a digit each step, so the product of the
   // low multiplier digit lands at its proper weight without a barrel shift.
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = PBITS'(a);
         b_in    = b;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + a_ff * PBITS'(b_ff[DBITS-1:0]);
         a_in   = a_ff << DBITS;
         b_in   = b_ff >> DBITS;
         if (b_in == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign product   = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ test/tb_regime_gated_band_reversion.sv @@
// Self-checking testbench for the band reversion block with efficiency ratio gate.
`timescale 1ns / 1ps

module tb_regime_gated_band_reversion;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int          PHASE_BARS  = 60;

   typedef enum int {
      SER_WALK,
      SER_TREND,
      SER_FLAT,
      SER_SETTLE,
      SER_SPIKY,
      SER_NOISE,
      SER_BROKEN
   } series_kind_type;

   typedef struct {
      int                bar;
      logic signed [1:0] direction;
      logic              history_ready;
   } band_call_type;

   // Tracks the close history and settings, and holds the calls still owed by the block.
   class reversion_tracker;
      logic [rgbr_pkg::CLOSE_BITS-1:0] closes [rgbr_pkg::BAND_WINDOW];
      int unsigned                     slot;
      int unsigned                     held;
      logic                            gate_on;
      logic [rgbr_pkg::PCT_BITS-1:0]   thresh;
      logic [rgbr_pkg::MULT_BITS-1:0]  mult;
      band_call_type                   awaited[$];
      int                              bars_noted;
      int                              mismatches;

      function new();
         slot       = 0;
         held       = 0;
         gate_on    = rgbr_pkg::GATE_RESET;
         thresh     = rgbr_pkg::THRESH_RESET;
         mult       = rgbr_pkg::MULT_RESET;
         bars_noted = 0;
         mismatches = 0;
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         mismatches++;
      endtask

      function void set_reg(logic [rgbr_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [rgbr_pkg::CSR_DATA_BITS-1:0] val);
         case (idx)
            rgbr_pkg::CSR_GATE_ENABLE:     gate_on = val[0];
            rgbr_pkg::CSR_RATIO_THRESHOLD: thresh = val[rgbr_pkg::PCT_BITS-1:0];
            rgbr_pkg::CSR_BAND_MULT:       mult = val[rgbr_pkg::MULT_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Close held j bars back, 1 <= j <= BAND_WINDOW.
      function logic [rgbr_pkg::CLOSE_BITS-1:0] lagged(int unsigned j);
         return closes[(slot + rgbr_pkg::BAND_WINDOW - (j % rgbr_pkg::BAND_WINDOW))
                       % rgbr_pkg::BAND_WINDOW];
      endfunction

      function logic [63:0] gap_between(logic [rgbr_pkg::CLOSE_BITS-1:0] a,
                                        logic [rgbr_pkg::CLOSE_BITS-1:0] b);
         logic [63:0] wa, wb;
         wa = a;
         wb = b;
         return (wa >= wb) ? wa - wb : wb - wa;
      endfunction

      // The trend is too efficient when net move / total path reaches the threshold.
      function bit ratio_suppresses(logic [rgbr_pkg::CLOSE_BITS-1:0] c);
         logic [63:0] move, path, pct;
         move = gap_between(c, lagged(rgbr_pkg::RATIO_LOOKBACK));
         path = gap_between(c, lagged(1));
         for (int k = 1; k < rgbr_pkg::RATIO_LOOKBACK; k++) begin
            path += gap_between(lagged(k), lagged(k + 1));
         end
         pct = thresh;
         return move * 64'd100 >= pct * path;
      endfunction

      // Band test without division or root:
      // (W*c - S)^2 * 100 * (W-1) against mult^2 * W * (W*Q - S^2).
      function logic signed [1:0] band_call(logic [rgbr_pkg::CLOSE_BITS-1:0] c);
         logic [127:0] total, sqsum, x, spread, wc, dev, lhs, rhs, m;
         logic         below;
         total = '0;
         sqsum = '0;
         for (int j = 1; j <= rgbr_pkg::BAND_WINDOW; j++) begin
            x = lagged(j);
            total += x;
            sqsum += x * x;
         end
         spread = 128'(rgbr_pkg::BAND_WINDOW) * sqsum - total * total;
         if (spread == 0) return rgbr_pkg::DIR_NONE;
         wc = 128'(rgbr_pkg::BAND_WINDOW) * 128'(c);
         if (wc == total) return rgbr_pkg::DIR_NONE;
         below = wc < total;
         dev = below ? total - wc : wc - total;
         m = mult;
         lhs = dev * dev * 128'(rgbr_pkg::PCT_SCALE * (rgbr_pkg::BAND_WINDOW - 1));
         rhs = spread * (m * m * 128'(rgbr_pkg::BAND_WINDOW));
         if (lhs <= rhs) return rgbr_pkg::DIR_NONE;
         return below ? rgbr_pkg::DIR_LONG : rgbr_pkg::DIR_SHORT;
      endfunction

      function void note_bar(logic [rgbr_pkg::CLOSE_BITS-1:0] c, logic clr);
         band_call_type r;
         if (clr) begin
            held = 0;
            slot = 0;
         end
         r.bar = bars_noted++;
         r.history_ready = (held >= rgbr_pkg::BAND_WINDOW);
         r.direction = rgbr_pkg::DIR_NONE;
         if (r.history_ready && !(gate_on && ratio_suppresses(c))) begin
            r.direction = band_call(c);
         end
         closes[slot] = c;
         slot = (slot + 1) % rgbr_pkg::BAND_WINDOW;
         if (held < rgbr_pkg::BAND_WINDOW) held++;
         awaited = {awaited, r};
      endfunction

      task check_call(logic signed [1:0] direction, logic history_ready);
         band_call_type r;
         if (awaited.size() == 0) begin
            report($sformatf("response beat with no bar outstanding (dir %0d)", direction));
         end else begin
            r = awaited.pop_front();
            if (direction !== r.direction)
               report($sformatf("bar %0d: direction %0d, expected %0d",
                                r.bar, direction, r.direction));
            if (history_ready !== r.history_ready)
               report($sformatf("bar %0d: history_ready %b, expected %b",
                                r.bar, history_ready, r.history_ready));
         end
      endtask
   endclass

   logic                               clock;
   logic                               reset;
   logic                               csr_wr_en;
   logic [rgbr_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [rgbr_pkg::CSR_DATA_BITS-1:0] csr_wr_data;

   rgbr_req_if req_bus ();
   rgbr_rsp_if rsp_bus ();

   regime_gated_band_reversion dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   reversion_tracker tracker;
   bit               calm;
   int               bars_sent;
   int unsigned      cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly short gaps, a few long ones; none at all during a calm stretch.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_bar(logic [rgbr_pkg::CLOSE_BITS-1:0] price, logic clr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.close_price   <= price;
      req_bus.clear_history <= clr;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_bar(price, clr);
      bars_sent++;
   endtask

   // Three back-to-back register writes; the enable is raised and lowered once.
   task automatic apply_settings(logic gate, logic [rgbr_pkg::PCT_BITS-1:0] thr,
                                 logic [rgbr_pkg::MULT_BITS-1:0] mul);
      logic [rgbr_pkg::CSR_IDX_BITS-1:0]  idx [3];
      logic [rgbr_pkg::CSR_DATA_BITS-1:0] val [3];
      idx = '{rgbr_pkg::CSR_GATE_ENABLE, rgbr_pkg::CSR_RATIO_THRESHOLD,
              rgbr_pkg::CSR_BAND_MULT};
      val = '{rgbr_pkg::CSR_DATA_BITS'(gate), rgbr_pkg::CSR_DATA_BITS'(thr),
              rgbr_pkg::CSR_DATA_BITS'(mul)};
      csr_wr_en <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index   <= idx[i];
         csr_wr_data <= val[i];
         @(posedge clock);
         tracker.set_reg(idx[i], val[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain_calls();
      req_bus.valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic series_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return SER_WALK;
      case (r)
         4:       return SER_TREND;
         5:       return SER_FLAT;
         6:       return SER_SETTLE;
         7:       return SER_SPIKY;
         8:       return SER_NOISE;
         default: return SER_BROKEN;
      endcase
   endfunction

   // One price series, opened by a clear. A broken series is too short to fill
   // the window; a noise series clears again at random.
   task automatic run_series(series_kind_type kind);
      longint      px, sign, stride;
      int unsigned len;
      bit          clr;
      len    = (kind == SER_BROKEN) ? $urandom_range(3, 19) : $urandom_range(22, 45);
      stride = longint'(1) << $urandom_range(0, 26);
      px     = longint'($urandom);
      sign   = $urandom_range(0, 1) ? 1 : -1;
      calm   = ($urandom_range(0, 4) == 0);
      if (kind == SER_FLAT) begin
         case ($urandom_range(0, 3))
            0:       px = 0;
            1:       px = longint'(32'hFFFF_FFFF);
            default: ;
         endcase
      end
      for (int i = 0; i < len; i++) begin
         clr = (i == 0) || (kind == SER_NOISE && $urandom_range(0, 9) == 0);
         case (kind)
            SER_WALK, SER_SPIKY: begin
               px += longint'($urandom_range(0, 2 * stride)) - stride;
               if ($urandom_range(0, (kind == SER_SPIKY) ? 2 : 9) == 0)
                  px += ($urandom_range(0, 1) ? 1 : -1) * stride
                        * longint'($urandom_range(4, 12));
            end
            SER_TREND:
               px += sign * stride * longint'($urandom_range(0, 3))
                     + longint'($urandom_range(0, stride)) - stride / 2;
            SER_SETTLE:
               if (i < 10) px = longint'($urandom);
            SER_NOISE, SER_BROKEN:
               px = longint'($urandom);
            default: ;
         endcase
         if (px < 0) px = 0;
         else if (px > longint'(32'hFFFF_FFFF)) px = longint'(32'hFFFF_FFFF);
         send_bar(px[rgbr_pkg::CLOSE_BITS-1:0], clr);
      end
   endtask

   // Response side: random stalls, with calm stretches of steady ready.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_call(rsp_bus.direction, rsp_bus.history_ready);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      tracker = new();
      cycle_count = 0;
      bars_sent   = 0;
      calm        = 1'b0;
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_index             <= rgbr_pkg::CSR_GATE_ENABLE;
      csr_wr_data           <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.close_price   <= '0;
      req_bus.clear_history <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      apply_settings(rgbr_pkg::GATE_RESET, rgbr_pkg::THRESH_RESET, rgbr_pkg::MULT_RESET);

      // Fill the window with alternating price extremes, mean exactly 0x7FFFFFFF.
      for (int i = 0; i < rgbr_pkg::BAND_WINDOW; i++)
         send_bar((i % 2) ? 32'hFFFF_FFFE : 32'h0, i == 0);
      send_bar(32'h7FFF_FFFF, 1'b0);   // close sits exactly on the mean
      send_bar(32'hFFFF_FFFF, 1'b0);
      send_bar(32'h0, 1'b0);
      send_bar(32'hFFFF_FFFF, 1'b1);   // clear with a full window held

      for (int p = 0; p < 7; p++) begin
         int start;
         drain_calls();
         repeat (4) @(posedge clock);
         case (p)
            0:       apply_settings(1'b0, 7'd0, 7'd0);
            1:       apply_settings(1'b1, 7'd127, 7'd1);
            2:       apply_settings(1'b1, 7'd100, 7'd127);
            3:       apply_settings(1'b1, 7'd0, 7'd10);
            4:       apply_settings(1'b1, 7'($urandom_range(0, 127)),
                                    7'($urandom_range(0, 127)));
            5:       apply_settings(1'b0, 7'($urandom_range(0, 127)),
                                    7'($urandom_range(1, 40)));
            default: apply_settings(1'b1, 7'd60, 7'd15);
         endcase
         start = bars_sent;
         // Every series shape opens one phase; the rest are drawn at random.
         run_series(series_kind_type'(p));
         while (bars_sent - start < PHASE_BARS) run_series(pick_kind());
      end

      drain_calls();
      repeat (50) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
